// File: src/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared constants for the stream find-and-replace block: default sizes,
// configuration register indexes and fixed port widths.
// ----------------------------------------------------------------------------
package sfr_pkg;

	// default window and replacement depths in bytes
	localparam int PATTERN_MAX_DEF = 8;
	localparam int REPLACE_MAX_DEF = 8;

	// configuration port
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 64;

	// bytes held by the 64-bit pattern and replacement registers
	localparam int WORD_BYTES = 8;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LEN       = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LEN   = 2'd3;

	// length register width
	localparam int LEN_W = 4;

endpackage

// File: src/stream_find_replace.sv
// ----------------------------------------------------------------------------
// stream_find_replace
// Replaces every leftmost, non-overlapping occurrence of a configured pattern
// in a byte stream by a configured replacement, one text byte per transfer.
// ----------------------------------------------------------------------------
// Output: a transfer's first result is registered with it if the output register is
// free, else it waits in the result buffer; buffered results leave one per cycle
// unless m_tready stalls. Throughput: one input transfer per cycle while each yields
// at most one result without a stall; s_tready is low while results are buffered.
// Reset: clears configuration, window fill count and output valid; the window
// bytes themselves are not reset.
module stream_find_replace #(
	parameter int PATTERN_MAX = sfr_pkg::PATTERN_MAX_DEF,
	parameter int REPLACE_MAX = sfr_pkg::REPLACE_MAX_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// configuration write port
	input  logic                           cfg_we,
	input  logic [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	// input stream
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [7:0]                     s_tdata,   // [7:0] in_char
	input  logic                           s_tuser,   // [0] char_present
	input  logic                           s_tlast,   // text_end
	// output stream
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [7:0]                     m_tdata,   // [7:0] out_char
	output logic [1:0]                     m_tuser,   // [0] char_valid, [1] run_last
	output logic                           m_tlast    // text_done
);

	localparam int NRES = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
	localparam int PCW  = $clog2(PATTERN_MAX + 1);
	localparam int RCW  = $clog2(REPLACE_MAX + 1);
	localparam int NCW  = $clog2(NRES + 1);
	localparam int IW   = (NRES > 1) ? $clog2(NRES) : 1;
	localparam logic [sfr_pkg::LEN_W:0] PM_LIM = (sfr_pkg::LEN_W + 1)'(PATTERN_MAX);
	localparam logic [sfr_pkg::LEN_W:0] RM_LIM = (sfr_pkg::LEN_W + 1)'(REPLACE_MAX);

	// configuration registers
	logic [sfr_pkg::CFG_DATA_W-1:0] pat_q;
	logic [sfr_pkg::LEN_W-1:0]      plen_q;
	logic [sfr_pkg::CFG_DATA_W-1:0] rep_q;
	logic [sfr_pkg::LEN_W-1:0]      rlen_q;

	// pending window
	logic [7:0]     win_q [PATTERN_MAX];
	logic [PCW-1:0] cnt_q;

	// result buffer
	logic [7:0]     buf_q [NRES];
	logic [NCW-1:0] buf_cnt_q;
	logic [NCW-1:0] buf_idx_q;
	logic           buf_end_q;
	logic           buf_cv_q;

	// output register
	logic           m_tvalid_q;
	logic [7:0]     out_char_q;
	logic           out_cv_q;
	logic           out_last_q;
	logic           out_done_q;

	// per-item logic
	logic [PCW-1:0] plen;
	logic [RCW-1:0] rlen;
	logic [PCW-1:0] cnt0;
	logic [PCW:0]   cnt1;
	logic [7:0]     pat_b [PATTERN_MAX];
	logic [7:0]     rep_b [NRES];
	logic [7:0]     w     [PATTERN_MAX];
	logic [7:0]     w_ext [NRES];
	logic [7:0]     w_sh  [PATTERN_MAX];
	logic [PATTERN_MAX-1:0] eq;
	logic           present;
	logic           last_in;
	logic           passthru;
	logic           full;
	logic           hit;
	logic           miss;
	logic [7:0]     res [NRES];
	logic [NCW-1:0] n;
	logic           res_cv;
	logic [PCW-1:0] cnt_nxt;
	logic           accept;
	logic           out_free;
	logic           buf_empty;
	logic           from_buf;
	logic [NCW-1:0] idx_inc;

	assign present  = s_tuser;
	assign last_in  = s_tlast;
	assign accept   = s_tvalid & s_tready;
	assign out_free = ~m_tvalid_q | m_tready;
	assign buf_empty = (buf_idx_q == buf_cnt_q);
	assign from_buf = ~buf_empty & out_free;
	assign idx_inc  = buf_idx_q + NCW'(1);

	// effective lengths, clamped to the configured depths
	assign plen = ({1'b0, plen_q} > PM_LIM) ? PCW'(PATTERN_MAX) : PCW'(plen_q);
	assign rlen = ({1'b0, rlen_q} > RM_LIM) ? RCW'(REPLACE_MAX) : RCW'(rlen_q);

	// fill count, dropped if it no longer fits the pattern
	assign cnt0 = (cnt_q >= plen) ? '0 : cnt_q;
	assign cnt1 = {1'b0, cnt0} + (PCW + 1)'(1);

	// pattern bytes, zero beyond the register
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_pat
		if (k < sfr_pkg::WORD_BYTES) begin : g_in
			assign pat_b[k] = pat_q[8*k +: 8];
		end else begin : g_out
			assign pat_b[k] = 8'h00;
		end
	end

	// replacement bytes, zero beyond the register or the depth
	for (genvar k = 0; k < NRES; k++) begin : g_rep
		if (k < sfr_pkg::WORD_BYTES && k < REPLACE_MAX) begin : g_in
			assign rep_b[k] = rep_q[8*k +: 8];
		end else begin : g_out
			assign rep_b[k] = 8'h00;
		end
	end

	// window with the new byte placed, its compare and its shifted form
	for (genvar k = 0; k < PATTERN_MAX; k++) begin : g_win
		assign w[k]  = (present && plen != '0 && cnt0 == PCW'(k)) ? s_tdata : win_q[k];
		assign eq[k] = (w[k] == pat_b[k]) || (PCW'(k) >= plen);
		if (k < PATTERN_MAX - 1) begin : g_sh
			assign w_sh[k] = w[k+1];
		end else begin : g_sh_end
			assign w_sh[k] = w[k];
		end
	end

	for (genvar k = 0; k < NRES; k++) begin : g_wext
		if (k < PATTERN_MAX) begin : g_in
			assign w_ext[k] = w[k];
		end else begin : g_out
			assign w_ext[k] = 8'h00;
		end
	end

	// item classification
	assign passthru = present && (plen == '0);
	assign full     = present && (plen != '0) && (cnt1 == {1'b0, plen});
	assign hit      = full && (&eq);
	assign miss     = full && !(&eq);

	// result list and new fill count
	always_comb begin
		n       = '0;
		res_cv  = 1'b1;
		cnt_nxt = cnt0;
		for (int i = 0; i < NRES; i++) begin
			if (passthru) begin
				res[i] = (i == 0) ? s_tdata : 8'h00;
			end else if (hit) begin
				res[i] = rep_b[i];
			end else begin
				res[i] = w_ext[i];
			end
		end
		if (passthru) begin
			n       = NCW'(1);
			cnt_nxt = '0;
		end else if (hit) begin
			n       = NCW'(rlen);
			cnt_nxt = '0;
		end else if (miss) begin
			n       = last_in ? NCW'(plen) : NCW'(1);
			cnt_nxt = last_in ? '0 : plen - PCW'(1);
		end else if (present) begin
			n       = last_in ? NCW'(cnt1) : '0;
			cnt_nxt = last_in ? '0 : cnt1[PCW-1:0];
		end else begin
			n       = last_in ? NCW'(cnt0) : '0;
			cnt_nxt = last_in ? '0 : cnt0;
		end
		// bare end marker when the final item has nothing to emit
		if (last_in && n == '0) begin
			n      = NCW'(1);
			res_cv = 1'b0;
			for (int i = 0; i < NRES; i++) begin
				res[i] = 8'h00;
			end
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q      <= '0;
			plen_q     <= '0;
			rep_q      <= '0;
			rlen_q     <= '0;
			cnt_q      <= '0;
			buf_cnt_q  <= '0;
			buf_idx_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			// item transfer: update fill count and load result buffer
			if (accept) begin
				cnt_q     <= cnt_nxt;
				buf_cnt_q <= n;
				buf_idx_q <= (out_free && n != '0) ? NCW'(1) : '0;
			end else if (from_buf) begin
				buf_idx_q <= idx_inc;
			end
			// output register valid
			if ((accept && n != '0 && out_free) || from_buf) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			// configuration writes
			if (cfg_we) begin
				case (cfg_index)
					sfr_pkg::REG_PATTERN_BYTES: pat_q <= cfg_data;
					sfr_pkg::REG_PATTERN_LEN: begin
						plen_q <= cfg_data[sfr_pkg::LEN_W-1:0];
						cnt_q  <= '0;
					end
					sfr_pkg::REG_REPLACEMENT_BYTES: rep_q <= cfg_data;
					sfr_pkg::REG_REPLACEMENT_LEN: rlen_q <= cfg_data[sfr_pkg::LEN_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// payload: window, result buffer, output register
	always_ff @(posedge clk) begin
		if (accept) begin
			for (int k = 0; k < PATTERN_MAX; k++) begin
				win_q[k] <= miss ? w_sh[k] : w[k];
			end
			for (int i = 0; i < NRES; i++) begin
				buf_q[i] <= res[i];
			end
			buf_end_q <= last_in;
			buf_cv_q  <= res_cv;
			if (out_free) begin
				out_char_q <= res[0];
				out_cv_q   <= res_cv;
				out_last_q <= (n == NCW'(1));
				out_done_q <= (n == NCW'(1)) && last_in;
			end
		end else if (from_buf) begin
			out_char_q <= buf_q[buf_idx_q[IW-1:0]];
			out_cv_q   <= buf_cv_q;
			out_last_q <= (idx_inc == buf_cnt_q);
			out_done_q <= (idx_inc == buf_cnt_q) && buf_end_q;
		end
	end

	// ports
	assign s_tready = buf_empty;
	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = {out_last_q, out_cv_q};
	assign m_tlast  = out_done_q;

endmodule
